>>> src/ldh_pkg.sv
// shared types and constants of the layer density histogram
package ldh_pkg;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 4;
  localparam int Z_W        = 32;
  localparam int RLAYER_W   = 8;
  localparam int RCOL_W     = 4;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LCOUNT_W   = 9;
  localparam int TCOUNT_W   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LAYER_W   = 3'd4;

  // command codes of an input word
  typedef enum logic [CMD_W-1:0] {
    CMD_ACCUM = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // counter memory address source
  typedef enum logic [1:0] {
    SEL_CLEAR,
    SEL_TYPE,
    SEL_TOTAL,
    SEL_READ
  } addr_sel_t;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_ABS,
    ST_PART,
    ST_SUM,
    ST_RD_TYPE,
    ST_WR_TYPE,
    ST_RD_TOTAL,
    ST_WR_TOTAL,
    ST_RD_MEM,
    ST_RD_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      load_item;
    logic      mem_re;
    logic      mem_we;
    logic      wr_zero;
    addr_sel_t addr_sel;
    logic      clear_step;
    logic      out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t op;
    logic kind_ok;
    logic read_ok;
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> src/ldh_channels.sv
// word channels of the layer density histogram
interface ldh_sample_if;
  logic                           valid;
  logic                           ready;
  logic [ldh_pkg::CMD_W-1:0]      cmd;
  logic [ldh_pkg::KIND_W-1:0]     atom_kind;
  logic signed [ldh_pkg::Z_W-1:0] z_reduced;
  logic [ldh_pkg::RLAYER_W-1:0]   read_layer;
  logic [ldh_pkg::RCOL_W-1:0]     read_column;

  modport source (output valid, cmd, atom_kind, z_reduced, read_layer, read_column,
                  input ready);
  modport sink   (input valid, cmd, atom_kind, z_reduced, read_layer, read_column,
                  output ready);
endinterface

interface ldh_count_if;
  logic                         valid;
  logic                         ready;
  logic [ldh_pkg::COUNT_W-1:0]  count_value;

  modport source (output valid, count_value, input ready);
  modport sink   (input valid, count_value, output ready);
endinterface

>>> src/ldh_datapath.sv
// datapath: config registers, layer arithmetic, counter memory and output register
module ldh_datapath #(
  parameter int MAX_LAYERS = 256,
  parameter int MAX_TYPES  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ldh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ldh_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [ldh_pkg::CMD_W-1:0]           sample_cmd,
  input  logic [ldh_pkg::KIND_W-1:0]          atom_kind,
  input  logic signed [ldh_pkg::Z_W-1:0]      z_reduced,
  input  logic [ldh_pkg::RLAYER_W-1:0]        read_layer,
  input  logic [ldh_pkg::RCOL_W-1:0]          read_column,
  input  ldh_pkg::dp_cmd_t                    ctl,
  output ldh_pkg::dp_stat_t                   stat,
  ldh_count_if.source                         counts
);
  import ldh_pkg::*;

  localparam int COLS  = MAX_TYPES + 1;
  localparam int DEPTH = MAX_LAYERS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LI_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int NL_W  = $clog2(MAX_LAYERS + 1);
  localparam int NT_W  = $clog2(MAX_TYPES + 1);

  // configuration registers
  logic [LCOUNT_W-1:0]     layer_count;
  logic [TCOUNT_W-1:0]     type_count;
  logic signed [Z_W-1:0]   box_left_z;
  logic [Z_W-1:0]          box_length_z;
  logic [Z_W-1:0]          inverse_layer_width;

  // captured word
  logic [CMD_W-1:0]        cmd_q;
  logic [KIND_W-1:0]       kind_q;
  logic signed [Z_W-1:0]   z_q;
  logic [RLAYER_W-1:0]     rl_q;
  logic [RCOL_W-1:0]       rc_q;

  // arithmetic stages
  logic signed [63:0]      prod;
  logic signed [63:0]      shifted_sum;
  logic [63:0]             sum_abs;
  logic [47:0]             mag;
  logic [55:0]             pp_hi;
  logic [55:0]             pp_lo;
  logic [79:0]             full_prod;
  logic [47:0]             scaled;
  logic [LI_W-1:0]         layer_idx;

  // effective limits
  logic [NL_W-1:0]         nl;
  logic [NT_W-1:0]         nt;

  // counter memory
  logic [COUNT_W-1:0]      mem [DEPTH];
  logic [COUNT_W-1:0]      rdata;
  logic [COUNT_W-1:0]      wdata;
  logic [AW-1:0]           addr;
  logic [AW-1:0]           type_addr;
  logic [AW-1:0]           total_addr;
  logic [AW-1:0]           read_addr;
  logic [AW-1:0]           clr_ptr;

  // output register
  logic                    out_valid;
  logic [COUNT_W-1:0]      count_value;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count         <= LCOUNT_W'(1);
      type_count          <= TCOUNT_W'(1);
      box_left_z          <= '0;
      box_length_z        <= Z_W'(65536);
      inverse_layer_width <= Z_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYER_COUNT:  layer_count         <= cfg_data[LCOUNT_W-1:0];
        REG_TYPE_COUNT:   type_count          <= cfg_data[TCOUNT_W-1:0];
        REG_BOX_LEFT_Z:   box_left_z          <= $signed(cfg_data[Z_W-1:0]);
        REG_BOX_LENGTH_Z: box_length_z        <= cfg_data[Z_W-1:0];
        REG_INV_LAYER_W:  inverse_layer_width <= cfg_data[Z_W-1:0];
        default: ;
      endcase
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q  <= sample_cmd;
      kind_q <= atom_kind;
      z_q    <= z_reduced;
      rl_q   <= read_layer;
      rc_q   <= read_column;
    end
  end

  // clamp layer and type counts
  always_comb begin
    if (layer_count == '0) begin
      nl = NL_W'(1);
    end else if (32'(layer_count) > 32'(MAX_LAYERS)) begin
      nl = NL_W'(MAX_LAYERS);
    end else begin
      nl = NL_W'(layer_count);
    end
    if (type_count == '0) begin
      nt = NT_W'(1);
    end else if (32'(type_count) > 32'(MAX_TYPES)) begin
      nt = NT_W'(MAX_TYPES);
    end else begin
      nt = NT_W'(type_count);
    end
  end

  // scale to box, floor to q16.16, add left edge, magnitude
  assign shifted_sum = (prod >>> 16) + 64'(box_left_z);
  assign sum_abs     = shifted_sum[63] ? 64'(-shifted_sum) : 64'(shifted_sum);
  assign full_prod   = {pp_hi, 24'd0} + 80'(pp_lo);

  // arithmetic pipeline, free running; the controller waits in its states while it settles
  always_ff @(posedge clk) begin
    prod  <= z_q * $signed({1'b0, box_length_z});
    mag   <= sum_abs[47:0];
    pp_hi <= mag[47:24] * inverse_layer_width;
    pp_lo <= mag[23:0] * inverse_layer_width;
    scaled <= full_prod[79:32];
    if (scaled >= 48'(nl)) begin
      layer_idx <= LI_W'(nl - NL_W'(1));
    end else begin
      layer_idx <= scaled[LI_W-1:0];
    end
  end

  // counter addresses
  assign type_addr  = AW'(32'(layer_idx) * COLS + 32'(kind_q) - 32'd1);
  assign total_addr = AW'(32'(layer_idx) * COLS + 32'(nt));
  assign read_addr  = AW'(32'(rl_q) * COLS + 32'(rc_q));

  always_comb begin
    unique case (ctl.addr_sel)
      SEL_CLEAR: addr = clr_ptr;
      SEL_TYPE:  addr = type_addr;
      SEL_TOTAL: addr = total_addr;
      SEL_READ:  addr = read_addr;
    endcase
  end

  // saturating increment or zero for the sweep
  always_comb begin
    if (ctl.wr_zero) begin
      wdata = '0;
    end else if (rdata == '1) begin
      wdata = rdata;
    end else begin
      wdata = rdata + COUNT_W'(1);
    end
  end

  // single port counter memory
  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem[addr] <= wdata;
    end
    if (ctl.mem_re) begin
      rdata <= mem[addr];
    end
  end

  // clear sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (ctl.clear_step) begin
      clr_ptr <= (clr_ptr == AW'(DEPTH - 1)) ? '0 : clr_ptr + AW'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (counts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      count_value <= stat.read_ok ? rdata : '0;
    end
  end

  assign counts.valid       = out_valid;
  assign counts.count_value = count_value;

  // status back to the controller
  assign stat.op         = cmd_t'(cmd_q);
  assign stat.kind_ok    = (kind_q != '0) && (32'(kind_q) <= 32'(nt));
  assign stat.read_ok    = (32'(rl_q) < 32'(nl)) && (32'(rc_q) <= 32'(nt));
  assign stat.clear_last = (clr_ptr == AW'(DEPTH - 1));
  assign stat.out_free   = !out_valid || counts.ready;

endmodule

>>> src/ldh_ctrl.sv
// controller: sequences arithmetic, counter updates, reads and clear sweeps
module ldh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ldh_pkg::dp_stat_t stat,
  output ldh_pkg::dp_cmd_t  ctl
);
  import ldh_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    ctl           = '0;
    ctl.addr_sel  = SEL_CLEAR;
    unique case (state)
      ST_CLEAR: begin
        ctl.mem_we     = 1'b1;
        ctl.wr_zero    = 1'b1;
        ctl.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.load_item = in_valid;
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.op)
          CMD_ACCUM: state_next = stat.kind_ok ? ST_MUL : ST_IDLE;
          CMD_READ:  state_next = stat.read_ok ? ST_RD_MEM : ST_RD_OUT;
          CMD_CLEAR: state_next = ST_CLEAR;
          default:   state_next = ST_IDLE;
        endcase
      end
      // arithmetic stages settle one per cycle
      ST_MUL:  state_next = ST_ABS;
      ST_ABS:  state_next = ST_PART;
      ST_PART: state_next = ST_SUM;
      ST_SUM:  state_next = ST_RD_TYPE;
      // per-type counter update
      ST_RD_TYPE: begin
        ctl.mem_re   = 1'b1;
        ctl.addr_sel = SEL_TYPE;
        state_next   = ST_WR_TYPE;
      end
      ST_WR_TYPE: begin
        ctl.mem_we   = 1'b1;
        ctl.addr_sel = SEL_TYPE;
        state_next   = ST_RD_TOTAL;
      end
      // total counter update
      ST_RD_TOTAL: begin
        ctl.mem_re   = 1'b1;
        ctl.addr_sel = SEL_TOTAL;
        state_next   = ST_WR_TOTAL;
      end
      ST_WR_TOTAL: begin
        ctl.mem_we   = 1'b1;
        ctl.addr_sel = SEL_TOTAL;
        state_next   = ST_IDLE;
      end
      // counter read
      ST_RD_MEM: begin
        ctl.mem_re   = 1'b1;
        ctl.addr_sel = SEL_READ;
        state_next   = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> src/layer_density_histogram.sv
// Layer density histogram: counts atom samples per z layer and atom type in a single
// port counter memory of MAX_LAYERS x (MAX_TYPES + 1) words, the last used column
// of each layer holding its total. After reset and after every clear command the
// memory is swept to zero one word a cycle and no word is taken during the sweep;
// configuration writes are taken at any time. Words are handled one at a time. An
// accumulate word passes through a decode state, the MUL, ABS, PART and SUM states
// of the scale, offset and split multiply chain, and two read-modify-write passes
// on the memory port before the next is taken. A sample with a bad atom type or an
// unused command goes back to idle from the decode state. A read passes through the
// decode, memory read and output states, skipping the memory read when its layer
// or column is out of range, and waits while the output register still holds an
// untaken result; that register lets the next word in while a result waits.
module layer_density_histogram #(
  parameter int MAX_LAYERS = 256,
  parameter int MAX_TYPES  = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ldh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ldh_pkg::CFG_DATA_W-1:0]  cfg_data,
  ldh_sample_if.sink                      samples,
  ldh_count_if.source                     counts
);
  import ldh_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;
  logic     in_ready;

  // sequencing
  ldh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  assign samples.ready = in_ready;

  // arithmetic and counter storage
  ldh_datapath #(
    .MAX_LAYERS (MAX_LAYERS),
    .MAX_TYPES  (MAX_TYPES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_cmd  (samples.cmd),
    .atom_kind   (samples.atom_kind),
    .z_reduced   (samples.z_reduced),
    .read_layer  (samples.read_layer),
    .read_column (samples.read_column),
    .ctl         (ctl),
    .stat        (stat),
    .counts      (counts)
  );

endmodule

>>> test/layer_density_histogram_tb.sv
// testbench of the layer density histogram: directed and random words checked against a tally
module layer_density_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ldh_pkg::*;

  localparam int MAX_LAYERS = 256;
  localparam int MAX_TYPES  = 8;
  localparam int COLS       = MAX_TYPES + 1;
  localparam int SETTLE_CYCLES = MAX_LAYERS * COLS + 24;
  localparam int QUIET_LIMIT   = 12000;
  localparam int STREAM_WORDS  = 210;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_FULL = 32'hFFFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ldh_sample_if sample_ch ();
  ldh_count_if  count_ch ();

  layer_density_histogram #(
    .MAX_LAYERS(MAX_LAYERS),
    .MAX_TYPES (MAX_TYPES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (sample_ch),
    .counts   (count_ch)
  );

  always #6 clk = ~clk;

  // own copy of the counter store and the registers
  logic [COUNT_W-1:0]    layer_tally [MAX_LAYERS*COLS];
  logic [LCOUNT_W-1:0]   layer_count_reg;
  logic [TCOUNT_W-1:0]   type_count_reg;
  logic signed [31:0]    box_left_reg;
  logic [31:0]           box_length_reg;
  logic [31:0]           inv_width_reg;

  typedef struct {
    logic [COUNT_W-1:0] value;
    int                 layer;
    int                 column;
  } awaited_count_t;

  awaited_count_t awaited_counts[$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int n_accum, n_read, n_clear, n_other, n_geometries;
  int counts_checked;
  int quiet_cycles;

  function automatic int live_layers();
    if (layer_count_reg < 1) return 1;
    if (layer_count_reg > MAX_LAYERS) return MAX_LAYERS;
    return int'(layer_count_reg);
  endfunction

  function automatic int live_types();
    if (type_count_reg < 1) return 1;
    if (type_count_reg > MAX_TYPES) return MAX_TYPES;
    return int'(type_count_reg);
  endfunction

  // random filler for fields a command ignores
  function automatic logic [KIND_W-1:0] any_kind();
    return KIND_W'($urandom);
  endfunction

  function automatic logic [RLAYER_W-1:0] any_layer();
    return RLAYER_W'($urandom);
  endfunction

  function automatic logic [RCOL_W-1:0] any_column();
    return RCOL_W'($urandom);
  endfunction

  // scale to the box, floor to Q16.16, offset, magnitude, times reciprocal width
  function automatic longint unsigned z_to_layer(input logic signed [31:0] z);
    longint          scaled;
    longint          offset_z;
    bit [63:0]       mag;
    bit [63:0]       acc;
    scaled   = longint'(z) * longint'({32'd0, box_length_reg});
    offset_z = (scaled >>> 16) + longint'(box_left_reg);
    mag      = (offset_z < 0) ? -offset_z : offset_z;
    acc      = mag * {48'd0, inv_width_reg[31:16]} +
               ((mag * {48'd0, inv_width_reg[15:0]}) >> 16);
    return acc >> 16;
  endfunction

  function automatic void bump_counter(input int addr);
    if (layer_tally[addr] != COUNT_FULL) layer_tally[addr] = layer_tally[addr] + 1;
  endfunction

  task automatic clear_tally();
    foreach (layer_tally[i]) layer_tally[i] = '0;
  endtask

  // update the tally for one accepted word, queue the count a read returns
  task automatic tally_word(input logic [CMD_W-1:0] cmd, input logic [KIND_W-1:0] kind,
                            input logic [Z_W-1:0] z, input logic [RLAYER_W-1:0] rl,
                            input logic [RCOL_W-1:0] rc);
    int              nl;
    int              nt;
    int              lay;
    longint unsigned idx;
    awaited_count_t  rec;
    nl = live_layers();
    nt = live_types();
    case (cmd)
      CMD_ACCUM: begin
        n_accum++;
        if (kind != 0 && kind <= nt) begin
          idx = z_to_layer(signed'(z));
          if (idx >= longint'(nl)) lay = nl - 1;
          else lay = int'(idx);
          bump_counter(lay * COLS + int'(kind) - 1);
          bump_counter(lay * COLS + nt);
        end
      end
      CMD_READ: begin
        n_read++;
        rec.layer  = int'(rl);
        rec.column = int'(rc);
        if (rl < nl && rc <= nt) rec.value = layer_tally[int'(rl) * COLS + int'(rc)];
        else rec.value = '0;
        awaited_counts.push_back(rec);
      end
      CMD_CLEAR: begin
        n_clear++;
        clear_tally();
      end
      default: n_other++;
    endcase
  endtask

  // present one word after a random gap and wait until it is taken
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KIND_W-1:0] kind,
                           input logic [Z_W-1:0] z, input logic [RLAYER_W-1:0] rl,
                           input logic [RCOL_W-1:0] rc);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.cmd         <= cmd;
    sample_ch.atom_kind   <= kind;
    sample_ch.z_reduced   <= z;
    sample_ch.read_layer  <= rl;
    sample_ch.read_column <= rc;
    do @(posedge clk); while (!sample_ch.ready);
    tally_word(cmd, kind, z, rl, rc);
  endtask

  task automatic hold_until_drained();
    sample_ch.valid <= 1'b0;
    while (awaited_counts.size() != 0) @(posedge clk);
  endtask

  // let the block finish any accumulate or clear sweep before registers change
  task automatic wait_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      REG_LAYER_COUNT:  layer_count_reg = value[LCOUNT_W-1:0];
      REG_TYPE_COUNT:   type_count_reg  = value[TCOUNT_W-1:0];
      REG_BOX_LEFT_Z:   box_left_reg    = signed'(value);
      REG_BOX_LENGTH_Z: box_length_reg  = value;
      REG_INV_LAYER_W:  inv_width_reg   = value;
      default: ;
    endcase
  endtask

  // junk above the count fields must be dropped by the block
  task automatic set_geometry(input int layers, input int types, input logic [31:0] left,
                              input logic [31:0] len, input logic [31:0] inv);
    write_reg(REG_LAYER_COUNT, ($urandom & ~32'h1FF) | 32'(layers));
    write_reg(REG_TYPE_COUNT, ($urandom & ~32'hF) | 32'(types));
    write_reg(REG_BOX_LEFT_Z, left);
    write_reg(REG_BOX_LENGTH_Z, len);
    write_reg(REG_INV_LAYER_W, inv);
    n_geometries++;
  endtask

  task automatic send_random_word();
    int                 nl;
    int                 nt;
    int                 pick;
    logic [CMD_W-1:0]   cmd;
    logic [KIND_W-1:0]  kind;
    logic [Z_W-1:0]     z;
    logic [RLAYER_W-1:0] rl;
    logic [RCOL_W-1:0]  rc;
    nl   = live_layers();
    nt   = live_types();
    pick = $urandom_range(99);
    kind = any_kind();
    z    = $urandom;
    rl   = any_layer();
    rc   = any_column();
    if (pick < 60) begin
      cmd = CMD_ACCUM;
      if ($urandom_range(99) < 88) kind = KIND_W'($urandom_range(nt, 1));
      if ($urandom_range(99) < 75) z = $urandom_range(131072) - 65536;
    end else if (pick < 93) begin
      cmd = CMD_READ;
      if ($urandom_range(99) < 85) begin
        rl = RLAYER_W'($urandom_range(nl - 1));
        rc = RCOL_W'($urandom_range(nt));
      end
    end else if (pick < 94) begin
      cmd = CMD_CLEAR;
    end else if (pick < 97) begin
      cmd = CMD_UNUSED;
    end else begin
      cmd = CMD_ACCUM;
    end
    send_word(cmd, kind, z, rl, rc);
  endtask

  // defaults after reset: one layer, one type, clamping, bad types, unused command
  task automatic test_reset_defaults();
    send_word(CMD_ACCUM, 4'd1, 32'h0000_0000, any_layer(), any_column());
    send_word(CMD_ACCUM, 4'd1, 32'h7FFF_FFFF, any_layer(), any_column());
    send_word(CMD_ACCUM, 4'd0, $urandom, any_layer(), any_column());
    send_word(CMD_ACCUM, 4'd2, $urandom, any_layer(), any_column());
    send_word(CMD_UNUSED, any_kind(), $urandom, any_layer(), any_column());
    send_word(CMD_READ, any_kind(), $urandom, 8'd0, 4'd0);
    send_word(CMD_READ, any_kind(), $urandom, 8'd0, 4'd1);
    send_word(CMD_READ, any_kind(), $urandom, 8'd0, 4'd2);
    send_word(CMD_READ, any_kind(), $urandom, 8'd1, 4'd0);
  endtask

  // full-size geometry, extreme coordinates, clear, then extreme register values
  task automatic test_geometry_extremes();
    wait_idle();
    set_geometry(256, 8, 32'h0000_0000, 32'h000A_0000, 32'h0019_999A);
    send_word(CMD_ACCUM, 4'd8, 32'h8000_0000, any_layer(), any_column());
    send_word(CMD_ACCUM, 4'd1, 32'h7FFF_FFFF, any_layer(), any_column());
    send_word(CMD_ACCUM, 4'd15, $urandom, any_layer(), any_column());
    send_word(CMD_ACCUM, 4'd4, 32'h0000_8000, any_layer(), any_column());
    send_word(CMD_READ, any_kind(), $urandom, 8'd255, 4'd7);
    send_word(CMD_READ, any_kind(), $urandom, 8'd255, 4'd8);
    send_word(CMD_READ, any_kind(), $urandom, 8'd128, 4'd3);
    send_word(CMD_READ, any_kind(), $urandom, 8'd255, 4'd9);
    send_word(CMD_CLEAR, any_kind(), $urandom, any_layer(), any_column());
    send_word(CMD_READ, any_kind(), $urandom, 8'd255, 4'd8);
    // counts below range clamp up, widest box and reciprocal
    wait_idle();
    set_geometry(0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_ACCUM, 4'd1, $urandom, any_layer(), any_column());
    send_word(CMD_READ, any_kind(), $urandom, 8'd0, 4'd1);
    // counts above range clamp down, zero box and reciprocal
    wait_idle();
    set_geometry(511, 15, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_ACCUM, 4'd8, $urandom, any_layer(), any_column());
    send_word(CMD_READ, any_kind(), $urandom, 8'd0, 4'd8);
  endtask

  // fewer types without a clear: column words stay where they were written
  task automatic test_type_count_change();
    wait_idle();
    set_geometry(4, 3, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
    send_word(CMD_ACCUM, 4'd3, 32'h0000_8000, any_layer(), any_column());
    wait_idle();
    write_reg(REG_TYPE_COUNT, 32'd2);
    send_word(CMD_READ, any_kind(), $urandom, 8'd0, 4'd2);
    send_word(CMD_READ, any_kind(), $urandom, 8'd0, 4'd3);
  endtask

  // random words under one geometry and one idling pattern
  task automatic test_streaming(input int phase);
    wait_idle();
    case (phase)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_geometry(16, 3, 32'h0000_0000, 32'h000A_0000, 32'h0001_999A);
      end
      1: begin
        send_idle_pct  = 49;
        recv_stall_pct = 0;
        set_geometry(256, 8, 32'hFFFB_0000, 32'h000A_0000, 32'h0011_1111);
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 49;
        set_geometry(300, 12, $urandom, $urandom, $urandom_range(32'h0010_0000));
      end
      default: begin
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        set_geometry(5, 2, 32'h0002_0000, 32'h0000_8000, 32'h0002_0000);
      end
    endcase
    for (int n = 0; n < STREAM_WORDS; n++) begin
      if (n == STREAM_WORDS / 2) hold_until_drained();
      send_random_word();
    end
  endtask

  // receiver readiness
  always @(posedge clk) begin
    count_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each count taken with the oldest pending read
  always @(posedge clk) begin : check_counts
    awaited_count_t head;
    if (!rst && count_ch.valid && count_ch.ready) begin
      if (awaited_counts.size() == 0) begin
        error_count++;
        $display("%0t: count %0h arrived with no read pending", $time, count_ch.count_value);
      end else begin
        head = awaited_counts.pop_front();
        counts_checked++;
        if (count_ch.count_value !== head.value) begin
          error_count++;
          $display("%0t: count of layer %0d column %0d: expected %0h, got %0h",
                   $time, head.layer, head.column, head.value, count_ch.count_value);
        end
      end
    end
  end

  // watchdog on cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (count_ch.valid && count_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d reads pending",
               $time, quiet_cycles, awaited_counts.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.cmd         = '0;
    sample_ch.atom_kind   = '0;
    sample_ch.z_reduced   = '0;
    sample_ch.read_layer  = '0;
    sample_ch.read_column = '0;
    clear_tally();
    layer_count_reg = 9'd1;
    type_count_reg  = 4'd1;
    box_left_reg    = '0;
    box_length_reg  = 32'h0001_0000;
    inv_width_reg   = 32'h0001_0000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_geometry_extremes();
    test_type_count_change();
    for (int p = 0; p < 4; p++) test_streaming(p);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d accumulates, %0d reads, %0d clears, %0d unused words over %0d geometries",
             n_accum, n_read, n_clear, n_other, n_geometries);
    $display("%0d counts compared with the predicted tally, %0d mismatches",
             counts_checked, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
